// ----- design/additive_oscillator_bank_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the additive oscillator bank
// Implication checks, same cycle and next cycle, with reset masking.
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_OSCILLATOR_BANK_TOP_MACROS_SVH
`define ADDITIVE_OSCILLATOR_BANK_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define AOB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/aob_pkg.sv -----
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types, codes, reset values and the sine generator function.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

  // default sizes
  localparam int unsigned NUM_BINS_DEF       = 128;
  localparam int unsigned PHASE_BITS_DEF     = 24;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned PROD_W             = 33;
  localparam int unsigned ACC_W_DEF          = PROD_W + 7;
  localparam int unsigned AMP_W              = 16;

  // configuration port
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_BINS_IN_USE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_STEP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_GAIN = 2'd2;

  localparam logic [7:0]  BINS_IN_USE_RST = 8'd120;
  localparam logic [23:0] BASE_STEP_RST   = 24'd13981;
  localparam logic [31:0] OUTPUT_GAIN_RST = 32'd178957;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // sample limits
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  // Q2.30 constants for the sine series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic             opcode;
    logic [6:0]       bin_index;
    logic [AMP_W-1:0] amplitude;
  } aob_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               overrange;
  } aob_out_t;

  // sin((pi/2) * r / 2^qbits) in Q1.15, Horner form to x^11, rounded to nearest
  function automatic logic signed [15:0] quarter_sine(input int unsigned r,
                                                      input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    x  = (HALF_PI_Q30 * 64'(r)) >> qbits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    t  = (x * t) >> 30;
    v  = (t * 64'd32767 + (64'd1 << 29)) >> 30;
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/aob_ram.sv -----
// ----------------------------------------------------------------------------
// aob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_ram #(
  parameter int unsigned WIDTH = aob_pkg::AMP_W,
  parameter int unsigned DEPTH = aob_pkg::NUM_BINS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/aob_sine_rom.sv -----
// ----------------------------------------------------------------------------
// aob_sine_rom
// Quarter-wave sine table with registered, sign-corrected output.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_sine_rom #(
  parameter int unsigned SINE_ADDR_BITS = aob_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic [SINE_ADDR_BITS-3:0] idx_i,
  input  logic                      peak_i,
  input  logic                      neg_i,
  output logic signed [15:0]        val_o
);

  import aob_pkg::*;

  localparam int unsigned QB    = SINE_ADDR_BITS - 2;
  localparam int unsigned QSIZE = 1 << QB;

  typedef logic signed [15:0] qtab_t [QSIZE];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int unsigned k = 0; k < QSIZE; k++) begin
      tab[k] = quarter_sine(k, QB);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  // value at exactly a quarter turn, outside the table
  localparam logic signed [15:0] PEAK = quarter_sine(QSIZE, QB);

  logic signed [15:0] mag;
  logic signed [15:0] val_q;

  assign mag = peak_i ? PEAK : QTAB[idx_i];

  // lower half of the wave is the negated upper half
  always_ff @(posedge clk_i) begin
    val_q <= neg_i ? -mag : mag;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ----- design/aob_scale.sv -----
// ----------------------------------------------------------------------------
// aob_scale
// Gain scaling of the bin sum, overrange detection and Q1.15 saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_scale #(
  parameter int unsigned ACC_W = aob_pkg::ACC_W_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] sum_i,
  input  logic [31:0]             gain_i,
  output logic                    done_o,
  output aob_pkg::aob_out_t       res_o
);

  import aob_pkg::*;

  localparam int unsigned AB_W = ACC_W + 16;
  localparam int unsigned PW   = ACC_W + 32;
  localparam logic [ACC_W-1:0] Q_ONE = ACC_W'(32768);
  localparam logic [ACC_W-1:0] Q_MAX = ACC_W'(32767);

  logic             v1_q, v2_q, done_q;
  logic             neg1_q, neg2_q;
  logic [ACC_W-1:0] sum_u;
  logic [ACC_W-1:0] mag_q;
  logic [AB_W-1:0]  a_q, b_q;
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] q;
  logic             sticky;
  aob_out_t         res_d, res_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  assign sum_u = sum_i;

  // magnitude, then two 16-bit slices of the gain
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg1_q <= sum_i[ACC_W-1];
      mag_q  <= sum_i[ACC_W-1] ? ACC_W'(~sum_u + 1'b1) : sum_u;
    end
    if (v1_q) begin
      neg2_q <= neg1_q;
      a_q    <= AB_W'(mag_q) * AB_W'(gain_i[31:16]);
      b_q    <= AB_W'(mag_q) * AB_W'(gain_i[15:0]);
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

  // full product: integer part from bit 32 up, fraction below
  assign prod   = {a_q, 16'h0000} + PW'(b_q);
  assign q      = prod[PW-1:32];
  assign sticky = |prod[31:0];

  // overrange, saturation and sign
  always_comb begin
    res_d = '0;
    if (!neg2_q) begin
      if ((q > Q_ONE) || ((q == Q_ONE) && sticky)) begin
        res_d.overrange = 1'b1;
      end else if (q > Q_MAX) begin
        res_d.sample = SAMPLE_MAX;
      end else begin
        res_d.sample = q[15:0];
      end
    end else begin
      if (q >= Q_ONE) begin
        res_d.sample = SAMPLE_MIN;
      end else begin
        res_d.sample = 16'h0000 - q[15:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- design/additive_oscillator_bank_top.sv -----
// ----------------------------------------------------------------------------
// additive_oscillator_bank_top: a load request writes the amplitude table; a tick issues
// its bins, one bin per cycle (none with under two bins), then presents its scaled sample.
// Sequential: the next request is taken once the tick's sample reaches the output register.
// Reset clears both tables by a sweep over all NUM_BINS entries; no request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "additive_oscillator_bank_top_macros.svh"

module additive_oscillator_bank_top #(
  parameter int unsigned NUM_BINS       = aob_pkg::NUM_BINS_DEF,
  parameter int unsigned PHASE_BITS     = aob_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_ADDR_BITS = aob_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aob_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [aob_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  aob_pkg::aob_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output aob_pkg::aob_out_t               out_data_o
);

  import aob_pkg::*;

  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned CNT_W = $clog2(NUM_BINS + 1);
  localparam int unsigned LIM_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int unsigned IDX_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned ACC_W = PROD_W + BIN_W;
  localparam int unsigned QB    = SINE_ADDR_BITS - 2;
  localparam logic [BIN_W-1:0] CLR_LAST = BIN_W'(NUM_BINS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // configuration registers
  logic [7:0]  bins_in_use_q;
  logic [23:0] base_step_q;
  logic [31:0] out_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_in_use_q <= BINS_IN_USE_RST;
      base_step_q   <= BASE_STEP_RST;
      out_gain_q    <= OUTPUT_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BINS_IN_USE: bins_in_use_q <= cfg_wdata_i[7:0];
        REG_BASE_STEP:   base_step_q   <= cfg_wdata_i[23:0];
        REG_OUTPUT_GAIN: out_gain_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]            state_q, state_d;
  logic [BIN_W-1:0]      clr_idx_q, clr_idx_d;
  logic [BIN_W-1:0]      idx_q, idx_d;
  logic [BIN_W-1:0]      last_q, last_d;
  logic [PHASE_BITS-1:0] inc_q, inc_d;
  logic                  s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic                  out_valid_q, out_valid_d;

  // request decode
  logic             accept, load, tick, in_range, clearing;
  logic [IDX_W-1:0] bin_ext;
  logic [LIM_W-1:0] bins_lim, bins_m1;
  logic             few;
  logic [PHASE_BITS-1:0] step_pb;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && (in_data_i.opcode == OP_LOAD);
  assign tick       = accept && (in_data_i.opcode == OP_TICK);
  assign bin_ext    = IDX_W'(in_data_i.bin_index);
  assign in_range   = bin_ext < IDX_W'(NUM_BINS);
  assign clearing   = (state_q == ST_CLEAR);
  assign step_pb    = PHASE_BITS'(base_step_q);

  // bins taken per tick, capped at the table size
  assign bins_lim = (LIM_W'(bins_in_use_q) > LIM_W'(NUM_BINS)) ? LIM_W'(NUM_BINS)
                                                               : LIM_W'(bins_in_use_q);
  assign bins_m1  = bins_lim - LIM_W'(1);
  assign few      = bins_lim <= LIM_W'(1);

  // pipeline wires
  logic                  pipe_busy;
  logic                  scale_start, scale_done;
  aob_out_t              scale_res;
  logic                  out_load;

  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    idx_d       = idx_q;
    last_d      = last_q;
    inc_d       = inc_q;
    scale_start = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick) begin
          idx_d   = BIN_W'(1);
          last_d  = bins_m1[BIN_W-1:0];
          inc_d   = step_pb;
          state_d = few ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        idx_d = idx_q + 1'b1;
        inc_d = inc_q + step_pb;
        if (idx_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          scale_start = 1'b1;
          state_d     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      idx_q     <= '0;
      last_q    <= '0;
      inc_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      idx_q     <= idx_d;
      last_q    <= last_d;
      inc_q     <= inc_d;
    end
  end

  // amplitude and phase tables
  logic                  amp_we, ph_we;
  logic [BIN_W-1:0]      amp_waddr, ph_waddr;
  logic [AMP_W-1:0]      amp_wdata, amp_rd;
  logic [PHASE_BITS-1:0] ph_wdata, ph_rd;

  assign amp_we    = clearing || (load && in_range);
  assign amp_waddr = clearing ? clr_idx_q : bin_ext[BIN_W-1:0];
  assign amp_wdata = clearing ? '0 : in_data_i.amplitude;

  aob_ram #(
    .WIDTH (AMP_W),
    .DEPTH (NUM_BINS)
  ) u_amp_ram (
    .clk_i   (clk_i),
    .we_i    (amp_we),
    .waddr_i (amp_waddr),
    .wdata_i (amp_wdata),
    .raddr_i (idx_q),
    .rdata_o (amp_rd)
  );

  aob_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (NUM_BINS)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (ph_waddr),
    .wdata_i (ph_wdata),
    .raddr_i (idx_q),
    .rdata_o (ph_rd)
  );

  // stage 1: read data back, advance the phase, write it to the same bin
  logic [BIN_W-1:0]          s1_idx_q;
  logic [PHASE_BITS-1:0]     s1_inc_q;
  logic [PHASE_BITS-1:0]     ph_next;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [QB-1:0]             sine_r, sine_r_neg, rom_idx;
  logic                      rom_peak;

  assign ph_next    = ph_rd + s1_inc_q;
  assign ph_we      = clearing || s1_v_q;
  assign ph_waddr   = clearing ? clr_idx_q : s1_idx_q;
  assign ph_wdata   = clearing ? '0 : ph_next;

  // quadrant folding onto the quarter table
  assign sine_addr  = ph_next[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign sine_r     = sine_addr[QB-1:0];
  assign sine_r_neg = '0 - sine_r;
  assign rom_idx    = sine_addr[QB] ? sine_r_neg : sine_r;
  assign rom_peak   = sine_addr[QB] && (sine_r == '0);

  // stage 2 to 4 payload and accumulator
  logic [QB-1:0]            s2_idx_q;
  logic                     s2_peak_q, s2_neg_q;
  logic [AMP_W-1:0]         s2_amp_q, s3_amp_q;
  logic signed [15:0]       sine_val;
  logic signed [PROD_W-1:0] amp_ext, sine_ext;
  logic signed [PROD_W-1:0] s4_prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  aob_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .idx_i  (s2_idx_q),
    .peak_i (s2_peak_q),
    .neg_i  (s2_neg_q),
    .val_o  (sine_val)
  );

  assign amp_ext  = {{(PROD_W - AMP_W){1'b0}}, s3_amp_q};
  assign sine_ext = {{(PROD_W - 16){sine_val[15]}}, sine_val};

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= (state_q == ST_RUN);
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // pipeline payload and accumulator
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= idx_q;
    s1_inc_q  <= inc_q;
    s2_idx_q  <= rom_idx;
    s2_peak_q <= rom_peak;
    s2_neg_q  <= sine_addr[QB+1];
    s2_amp_q  <= amp_rd;
    s3_amp_q  <= s2_amp_q;
    s4_prod_q <= amp_ext * sine_ext;
    if (tick) begin
      acc_q <= '0;
    end else if (s4_v_q) begin
      acc_q <= acc_q + ACC_W'(s4_prod_q);
    end
  end

  // gain and saturation
  aob_scale #(
    .ACC_W (ACC_W)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .sum_i   (acc_q),
    .gain_i  (out_gain_q),
    .done_o  (scale_done),
    .res_o   (scale_res)
  );

  // output register
  aob_out_t out_q;

  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= scale_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `AOB_ASSERT_IMP(a_prod_in_tick, clk_i, rst_ni, s4_v_q,
    (state_q == ST_RUN) || (state_q == ST_DRAIN), "bin product outside a tick")
  `AOB_ASSERT_IMP(a_amp_we_idle, clk_i, rst_ni, amp_we,
    (state_q == ST_IDLE) || (state_q == ST_CLEAR), "amplitude write during a tick")
  `AOB_ASSERT_IMP(a_issue_range, clk_i, rst_ni, state_q == ST_RUN,
    (idx_q != '0) && (idx_q <= last_q), "bin issue index out of range")
  `AOB_ASSERT_IMP(a_scale_lat, clk_i, rst_ni, scale_done,
    $past(scale_start, 3), "scale result without a start")
  `AOB_ASSERT_NXT(a_out_load, clk_i, rst_ni, out_load,
    out_valid_o && (state_q == ST_IDLE), "sample not presented after a tick")

endmodule

`default_nettype wire
